// ===== sv/pip_pkg.sv =====
// package: payload types and constants for the point in polygon tester
`default_nettype none
package pip_pkg;
  localparam int CoordW = 16;
  localparam int CountW = 7;
  localparam int IndexW = 6;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_VERTEX_COUNT = 2'd2;
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  typedef struct packed {
    logic req_type;
    logic [IndexW-1:0] vertex_index;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic result_kind;
    logic hit;
  } out_item_t;

  // token handed from cell to cell along the chain
  typedef struct packed {
    logic vld;
    logic odd;
    logic signed [CoordW:0] qx;
    logic signed [CoordW:0] qy;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
  } tok_t;
endpackage
`default_nettype wire

// ===== sv/pip_cell.sv =====
// cell: one polygon vertex, tests the edge to the previous vertex on the passing token
`default_nettype none
module pip_cell (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire logic signed [pip_pkg::CoordW-1:0] wr_x,
  input  wire logic signed [pip_pkg::CoordW-1:0] wr_y,
  input  wire logic active,
  input  wire logic is_last,
  input  wire logic signed [pip_pkg::CoordW-1:0] close_x,
  input  wire logic signed [pip_pkg::CoordW-1:0] close_y,
  input  wire pip_pkg::tok_t tok_i,
  output pip_pkg::tok_t tok_o,
  output logic signed [pip_pkg::CoordW-1:0] vx,
  output logic signed [pip_pkg::CoordW-1:0] vy
);
  localparam int W = pip_pkg::CoordW;
  logic signed [W-1:0] vx_r, vy_r;
  pip_pkg::tok_t tok_r, tok_nxt;
  logic signed [W+1:0] dxq, dyv, dxe, dyq;
  logic signed [2*W+3:0] lhs, rhs;
  logic straddle, left;

  always_comb begin
    dxq = {tok_i.qx[W], tok_i.qx} - {{2{vx_r[W-1]}}, vx_r};
    dyq = {tok_i.qy[W], tok_i.qy} - {{2{vy_r[W-1]}}, vy_r};
    dyv = {{2{tok_i.py[W-1]}}, tok_i.py} - {{2{vy_r[W-1]}}, vy_r};
    dxe = {{2{tok_i.px[W-1]}}, tok_i.px} - {{2{vx_r[W-1]}}, vx_r};
    lhs = dxq * dyv;
    rhs = dxe * dyq;
    straddle = ($signed({vy_r[W-1], vy_r}) > tok_i.qy)
               != ($signed({tok_i.py[W-1], tok_i.py}) > tok_i.qy);
    left = dyv[W+1] ? (lhs > rhs) : (lhs < rhs);
    tok_nxt = tok_i;
    tok_nxt.px = vx_r;
    tok_nxt.py = vy_r;
    if (active && straddle && left) begin
      tok_nxt.odd = ~tok_i.odd;
    end
    // last cell closes the polygon against vertex zero
    if (active && is_last) begin
      tok_nxt.px = close_x;
      tok_nxt.py = close_y;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vx_r <= wr_x;
      vy_r <= wr_y;
    end
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;
  assign vx = vx_r;
  assign vy = vy_r;
endmodule
`default_nettype wire

// ===== sv/point_in_polygon_test.sv =====
// top level: point in polygon tester built as a chain of vertex cells
// A vertex write is acknowledged in the cycle after acceptance. A point test
// enters a chain of MAX_VERTICES cells, one per vertex, and moves one cell
// per cycle; its answer is registered into the output once the token leaves
// the last cell. One item is in flight at a time, and the next item is
// taken at the earliest in the cycle after the result is accepted. The
// first edge pairs vertex 0 with the last vertex in use, which seeds the token.
`default_nettype none
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire pip_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output pip_pkg::out_item_t out_data,
  input  wire logic cfg_we,
  input  wire logic [pip_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [pip_pkg::CoordW-1:0] cfg_wdata
);
  localparam int W = pip_pkg::CoordW;
  localparam int N = MAX_VERTICES;
  localparam int AW = $clog2(N);

  logic signed [W-1:0] off_x_r, off_y_r;
  logic [pip_pkg::CountW-1:0] cnt_r;
  logic [AW:0] n_eff;
  logic busy_r, ovld_r, okind_r, ohit_r;
  pip_pkg::tok_t tok [N+1];
  logic signed [W-1:0] vx [N];
  logic signed [W-1:0] vy [N];
  logic accept;

  always_comb begin
    if ({{(AW+1){1'b0}}, cnt_r} > (AW+1+pip_pkg::CountW)'(N)) begin
      n_eff = (AW+1)'(N);
    end else begin
      n_eff = (AW+1)'(cnt_r);
    end
  end

  assign accept = in_valid && in_ready;
  assign in_ready = !busy_r && !ovld_r;

  logic signed [W-1:0] last_x, last_y;
  always_comb begin
    last_x = vx[0];
    last_y = vy[0];
    for (int k = 0; k < N; k++) begin
      if ((AW+1)'(k + 1) == n_eff) begin
        last_x = vx[k];
        last_y = vy[k];
      end
    end
  end

  always_comb begin
    tok[0].vld = accept && (in_data.req_type == pip_pkg::REQ_TEST);
    tok[0].odd = 1'b0;
    tok[0].qx = {in_data.coord_x[W-1], in_data.coord_x} - {off_x_r[W-1], off_x_r};
    tok[0].qy = {in_data.coord_y[W-1], in_data.coord_y} - {off_y_r[W-1], off_y_r};
    tok[0].px = last_x;
    tok[0].py = last_y;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    pip_cell u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .wr_en(accept && in_data.req_type == pip_pkg::REQ_WRITE
             && {{(32-pip_pkg::IndexW){1'b0}}, in_data.vertex_index} == g),
      .wr_x(in_data.coord_x),
      .wr_y(in_data.coord_y),
      .active((AW+1)'(g) < n_eff),
      .is_last(1'b0),
      .close_x(vx[0]),
      .close_y(vy[0]),
      .tok_i(tok[g]),
      .tok_o(tok[g+1]),
      .vx(vx[g]),
      .vy(vy[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      cnt_r <= '0;
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pip_pkg::CFG_OFFSET_X: off_x_r <= cfg_wdata;
          pip_pkg::CFG_OFFSET_Y: off_y_r <= cfg_wdata;
          pip_pkg::CFG_VERTEX_COUNT: cnt_r <= cfg_wdata[pip_pkg::CountW-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        ovld_r <= 1'b0;
      end
      if (accept) begin
        if (in_data.req_type == pip_pkg::REQ_TEST) begin
          busy_r <= 1'b1;
        end else begin
          ovld_r <= 1'b1;
          okind_r <= pip_pkg::REQ_WRITE;
          ohit_r <= 1'b0;
        end
      end
      if (busy_r && tok[N].vld) begin
        busy_r <= 1'b0;
        ovld_r <= 1'b1;
        okind_r <= pip_pkg::REQ_TEST;
        ohit_r <= tok[N].odd;
      end
    end
  end

  assign out_valid = ovld_r;
  assign out_data.result_kind = okind_r;
  assign out_data.hit = ohit_r;
endmodule
`default_nettype wire
